@@ sv/gss_pkg.sv @@
// ----------------------------------------------------------------------------
// gss_pkg
// Types and constants shared by the Gray-Scott strip step block.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam logic [15:0] ONE_Q15          = 16'd32768;
    localparam logic [15:0] IMPACT_THRESHOLD = 16'd1638;
    localparam logic [15:0] DIFF_U_RESET     = 16'd32768;
    localparam logic [15:0] DIFF_V_RESET     = 16'd16384;
    localparam int          CFG_IDX_W        = 1;

    typedef enum logic {
        OP_STEP = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIFF_U = 1'b0,
        CFG_DIFF_V = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op         op;
        logic [15:0] feed_rate;
        logic [15:0] kill_rate;
        logic [15:0] time_step;
        logic [1:0]  iterations;
        logic [15:0] impact_level;
        logic [6:0]  cell_index;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_u;
        logic [15:0] cell_v;
        logic        step_done;
    } t_out;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic pass_ev;
        logic pass_rd;
        logic pass_first;
        logic pass_last;
        logic inj_rd;
        logic cell_rd;
        logic out_step;
        logic out_read;
        logic bank;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

@@ sv/gray_scott_strip_step.sv @@
// ----------------------------------------------------------------------------
// gray_scott_strip_step
// One-dimensional Gray-Scott reaction-diffusion strip with centre injection.
// ----------------------------------------------------------------------------
// After reset the block sweeps its concentration memory, one cell per
// cycle, and accepts no item until the sweep is done. A read addresses the
// memory in S_RD and loads the result register in S_FIN once the output is
// free. A step streams every cell through an eight-stage update pipeline
// once per pass, then runs the injection pipeline when the impact is large
// enough. The single read port of each memory sets the one-cell-per-cycle
// pace. One item is in work at a time, and the next item is taken while a
// finished result waits in the output register.
// ----------------------------------------------------------------------------
module gray_scott_strip_step #(
    parameter int CELLS           = 128,
    parameter int SEED_HALF_WIDTH = 6,
    parameter int INJECT_RADIUS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gss_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gss_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_wdata
);

    localparam int CW  = $clog2(CELLS + 1);
    localparam int IWW = $clog2(INJECT_RADIUS + 1);

    gss_pkg::t_cmd  w_cmd;
    gss_pkg::t_sts  w_sts;
    logic [CW-1:0]  w_cnt;
    logic [IWW-1:0] w_inj_w;

    gss_ctrl #(
        .CELLS         (CELLS),
        .INJECT_RADIUS (INJECT_RADIUS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_cnt      (w_cnt),
        .o_inj_w    (w_inj_w)
    );

    gss_dp #(
        .CELLS           (CELLS),
        .SEED_HALF_WIDTH (SEED_HALF_WIDTH),
        .INJECT_RADIUS   (INJECT_RADIUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cnt       (w_cnt),
        .i_inj_w     (w_inj_w),
        .i_item      (i_in_data),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/gss_dp.sv @@
// ----------------------------------------------------------------------------
// gss_dp
// Datapath: concentration memories, the streaming update pipeline, the
// injection pipeline, configuration registers and the result register.
// ----------------------------------------------------------------------------
module gss_dp #(
    parameter int CELLS           = 128,
    parameter int SEED_HALF_WIDTH = 6,
    parameter int INJECT_RADIUS   = 8,
    localparam int AW  = $clog2(CELLS),
    localparam int CW  = $clog2(CELLS + 1),
    localparam int IWW = $clog2(INJECT_RADIUS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gss_pkg::t_cmd              i_cmd,
    input  logic [CW-1:0]              i_cnt,
    input  logic [IWW-1:0]             i_inj_w,
    input  gss_pkg::t_in               i_item,
    output gss_pkg::t_sts              o_sts,
    input  logic                       i_cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                i_cfg_wdata,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output gss_pkg::t_out              o_out_data
);

    localparam int XW      = 16 + IWW + 1;
    localparam int DIV     = 5 * INJECT_RADIUS;
    localparam int DW      = $clog2(DIV + 1);
    localparam int INJ_MUL = (2 ** XW) / DIV;
    localparam int MID     = CELLS / 2;
    localparam int SW      = AW + 2;

    logic [15:0] mem_u [2**(AW+1)];
    logic [15:0] mem_v [2**(AW+1)];

    logic [15:0] r_du, r_dv;
    gss_pkg::t_in r_item;
    logic [15:0] r_rd_u, r_rd_v;
    logic        r_cell_ok;

    // Update pipeline.
    logic          r_e_vld, r_e_first, r_e_last;
    logic [CW-1:0] r_e_s;
    logic          r_w_vld;
    logic [AW-1:0] r_w_idx;
    logic [15:0]   r_w_pu, r_w_cu, r_w_nu, r_w_pv, r_w_cv, r_w_nv;
    logic          r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_p5_vld, r_p6_vld;
    logic [AW-1:0] r_p1_idx, r_p2_idx, r_p3_idx, r_p4_idx, r_p5_idx, r_p6_idx;
    logic [15:0]   r_p1_u, r_p2_u, r_p3_u, r_p4_u, r_p5_u;
    logic [15:0]   r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v;
    logic signed [34:0] r_dul, r_dvl;
    logic [31:0]   r_fu, r_uv;
    logic [32:0]   r_fkv, r_uvv;
    logic signed [37:0] r_ru_a, r_rv_a, r_ru, r_rv;
    logic [33:0]   r_plo_u, r_plo_v;
    logic signed [36:0] r_phi_u, r_phi_v;
    logic signed [57:0] r_prod_u, r_prod_v;
    logic [15:0]   r_nu, r_nv;

    // Injection pipeline.
    logic           r_ie_vld, r_i1_vld, r_i2_vld, r_i3_vld, r_i4_vld;
    logic [AW-1:0]  r_ie_addr, r_i1_addr, r_i2_addr, r_i3_addr, r_i4_addr;
    logic [IWW-1:0] r_ie_w;
    logic [15:0]    r_i1_u, r_i2_u, r_i3_u, r_i1_v, r_i2_v, r_i3_v;
    logic [XW-1:0]  r_x, r_x2, r_qe, r_inj;
    logic [15:0]    r_iu, r_iv;

    logic        r_out_vld;
    gss_pkg::t_out r_out;

    logic          w_re, w_we;
    logic [AW:0]   w_raddr, w_waddr;
    logic [15:0]   w_wu, w_wv;
    logic [AW+6:0] w_cext;
    logic [AW-1:0] w_cidx;
    logic          w_crange;
    logic signed [SW-1:0] w_sdist;
    logic          w_seed;
    logic [15:0]   w_in_u, w_in_v;
    logic [CW-1:0] w_ctr;
    logic signed [17:0] w_lapu, w_lapv;
    logic signed [34:0] w_dul, w_dvl;
    logic [31:0]   w_fu, w_uv;
    logic [32:0]   w_fkv;
    logic [47:0]   w_uvv;
    logic [33:0]   w_plo_u, w_plo_v;
    logic signed [36:0] w_phi_u, w_phi_v;
    logic signed [57:0] w_su, w_sv;
    logic [XW-1:0] w_x;
    logic [2*XW-1:0] w_qm;
    logic [XW+DW-1:0] w_rr;
    logic [XW:0]   w_vs;
    logic [XW-1:0] w_half;

    function automatic logic [15:0] clamp58(input logic signed [57:0] s);
        logic [15:0] res;
        if (s < 0) begin
            res = 16'd0;
        end else if (s > $signed(58'(gss_pkg::ONE_Q15))) begin
            res = gss_pkg::ONE_Q15;
        end else begin
            res = s[15:0];
        end
        return res;
    endfunction

    always_comb begin
        w_cext   = (AW+7)'(r_item.cell_index);
        w_crange = w_cext < (AW+7)'(CELLS);
        w_cidx   = w_cext[AW-1:0];
        w_re     = i_cmd.pass_rd || i_cmd.inj_rd || i_cmd.cell_rd;
        w_raddr  = i_cmd.cell_rd ? {i_cmd.bank, w_cidx} : {i_cmd.bank, i_cnt[AW-1:0]};
        w_sdist  = $signed(SW'(i_cnt[AW-1:0])) - $signed(SW'(MID));
        w_seed   = (w_sdist <= $signed(SW'(SEED_HALF_WIDTH)))
                && (w_sdist >= -$signed(SW'(SEED_HALF_WIDTH)));
        priority if (i_cmd.clr_wr) begin
            w_we    = 1'b1;
            w_waddr = {1'b0, i_cnt[AW-1:0]};
            w_wu    = w_seed ? 16'd0 : gss_pkg::ONE_Q15;
            w_wv    = w_seed ? gss_pkg::ONE_Q15 : 16'd0;
        end else if (r_p6_vld) begin
            w_we    = 1'b1;
            w_waddr = {~i_cmd.bank, r_p6_idx};
            w_wu    = r_nu;
            w_wv    = r_nv;
        end else begin
            w_we    = r_i4_vld;
            w_waddr = {i_cmd.bank, r_i4_addr};
            w_wu    = r_iu;
            w_wv    = r_iv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_u[w_waddr] <= w_wu;
            mem_v[w_waddr] <= w_wv;
        end
        if (w_re) begin
            r_rd_u <= mem_u[w_raddr];
            r_rd_v <= mem_v[w_raddr];
        end
    end

    always_comb begin
        w_in_u = r_e_last ? r_w_nu : r_rd_u;
        w_in_v = r_e_last ? r_w_nv : r_rd_v;
        w_ctr  = r_e_s - CW'(1);
        w_lapu = $signed({2'b00, r_w_pu}) + $signed({2'b00, r_w_nu})
               - $signed({1'b0, r_w_cu, 1'b0});
        w_lapv = $signed({2'b00, r_w_pv}) + $signed({2'b00, r_w_nv})
               - $signed({1'b0, r_w_cv, 1'b0});
        w_dul  = $signed({1'b0, r_du}) * w_lapu;
        w_dvl  = $signed({1'b0, r_dv}) * w_lapv;
        w_fu   = r_item.feed_rate * (17'(gss_pkg::ONE_Q15) - 17'(r_w_cu));
        w_fkv  = (17'(r_item.feed_rate) + 17'(r_item.kill_rate)) * r_w_cv;
        w_uv   = r_w_cu * r_w_cv;
        w_uvv  = r_uv * r_p1_v;
        w_plo_u = r_ru[17:0] * r_item.time_step;
        w_plo_v = r_rv[17:0] * r_item.time_step;
        w_phi_u = $signed(r_ru[37:18]) * $signed({1'b0, r_item.time_step});
        w_phi_v = $signed(r_rv[37:18]) * $signed({1'b0, r_item.time_step});
        w_su   = $signed(58'(r_p5_u)) + (r_prod_u >>> 29);
        w_sv   = $signed(58'(r_p5_v)) + (r_prod_v >>> 29);
        w_x    = (XW'(r_item.impact_level) * XW'(r_ie_w)) << 1;
        w_qm   = (2*XW)'(r_x) * (2*XW)'(INJ_MUL);
        w_rr   = (XW+DW)'(r_x2) - (XW+DW)'(r_qe) * (XW+DW)'(DIV);
        w_vs   = (XW+1)'(r_i3_v) + (XW+1)'(r_inj);
        w_half = r_inj >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_du      <= gss_pkg::DIFF_U_RESET;
            r_dv      <= gss_pkg::DIFF_V_RESET;
            r_e_vld   <= 1'b0;
            r_w_vld   <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_ie_vld  <= 1'b0;
            r_i1_vld  <= 1'b0;
            r_i2_vld  <= 1'b0;
            r_i3_vld  <= 1'b0;
            r_i4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (gss_pkg::t_cfg_idx'(i_cfg_idx))
                    gss_pkg::CFG_DIFF_U: r_du <= i_cfg_wdata;
                    gss_pkg::CFG_DIFF_V: r_dv <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_e_vld  <= i_cmd.pass_ev;
            r_w_vld  <= r_e_vld && !r_e_first;
            r_p1_vld <= r_w_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
            r_p5_vld <= r_p4_vld;
            r_p6_vld <= r_p5_vld;
            r_ie_vld <= i_cmd.inj_rd;
            r_i1_vld <= r_ie_vld;
            r_i2_vld <= r_i1_vld;
            r_i3_vld <= r_i2_vld;
            r_i4_vld <= r_i3_vld;
            if (i_cmd.out_step || i_cmd.out_read) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.cell_rd) begin
            r_cell_ok <= w_crange;
        end
        r_e_first <= i_cmd.pass_first;
        r_e_last  <= i_cmd.pass_last;
        r_e_s     <= i_cnt;
        if (r_e_vld) begin
            r_w_idx <= w_ctr[AW-1:0];
            r_w_nu  <= w_in_u;
            r_w_nv  <= w_in_v;
            if (r_e_first) begin
                r_w_cu <= w_in_u;
                r_w_cv <= w_in_v;
            end else begin
                r_w_pu <= r_w_cu;
                r_w_cu <= r_w_nu;
                r_w_pv <= r_w_cv;
                r_w_cv <= r_w_nv;
            end
        end
        r_p1_idx <= r_w_idx;
        r_p1_u   <= r_w_cu;
        r_p1_v   <= r_w_cv;
        r_dul    <= w_dul;
        r_dvl    <= w_dvl;
        r_fu     <= w_fu;
        r_fkv    <= w_fkv;
        r_uv     <= w_uv;

        r_p2_idx <= r_p1_idx;
        r_p2_u   <= r_p1_u;
        r_p2_v   <= r_p1_v;
        r_uvv    <= w_uvv[47:15];
        r_ru_a   <= 38'(r_dul) + 38'(r_fu >> 1);
        r_rv_a   <= 38'(r_dvl) - 38'(r_fkv >> 1);

        r_p3_idx <= r_p2_idx;
        r_p3_u   <= r_p2_u;
        r_p3_v   <= r_p2_v;
        r_ru     <= r_ru_a - 38'(r_uvv);
        r_rv     <= r_rv_a + 38'(r_uvv);

        r_p4_idx <= r_p3_idx;
        r_p4_u   <= r_p3_u;
        r_p4_v   <= r_p3_v;
        r_plo_u  <= w_plo_u;
        r_plo_v  <= w_plo_v;
        r_phi_u  <= w_phi_u;
        r_phi_v  <= w_phi_v;

        r_p5_idx <= r_p4_idx;
        r_p5_u   <= r_p4_u;
        r_p5_v   <= r_p4_v;
        r_prod_u <= (58'(r_phi_u) <<< 18) + $signed(58'(r_plo_u));
        r_prod_v <= (58'(r_phi_v) <<< 18) + $signed(58'(r_plo_v));

        r_p6_idx <= r_p5_idx;
        r_nu     <= clamp58(w_su);
        r_nv     <= clamp58(w_sv);

        r_ie_addr <= i_cnt[AW-1:0];
        r_ie_w    <= i_inj_w;
        r_i1_addr <= r_ie_addr;
        r_i1_u    <= r_rd_u;
        r_i1_v    <= r_rd_v;
        r_x       <= w_x;
        r_i2_addr <= r_i1_addr;
        r_i2_u    <= r_i1_u;
        r_i2_v    <= r_i1_v;
        r_x2      <= r_x;
        r_qe      <= w_qm[2*XW-1:XW];
        r_i3_addr <= r_i2_addr;
        r_i3_u    <= r_i2_u;
        r_i3_v    <= r_i2_v;
        r_inj     <= (w_rr >= (XW+DW)'(DIV)) ? r_qe + XW'(1) : r_qe;
        r_i4_addr <= r_i3_addr;
        r_iv      <= (w_vs > (XW+1)'(gss_pkg::ONE_Q15)) ? gss_pkg::ONE_Q15 : w_vs[15:0];
        r_iu      <= (XW'(r_i3_u) >= w_half) ? r_i3_u - w_half[15:0] : 16'd0;

        if (i_cmd.out_step) begin
            r_out <= '{cell_u: 16'd0, cell_v: 16'd0, step_done: 1'b1};
        end else if (i_cmd.out_read) begin
            r_out <= '{cell_u: r_cell_ok ? r_rd_u : 16'd0,
                       cell_v: r_cell_ok ? r_rd_v : 16'd0,
                       step_done: 1'b0};
        end
    end

    always_comb begin
        o_sts.pipe_busy = r_e_vld || r_w_vld || r_p1_vld || r_p2_vld || r_p3_vld
                       || r_p4_vld || r_p5_vld || r_p6_vld || r_ie_vld || r_i1_vld
                       || r_i2_vld || r_i3_vld || r_i4_vld;
        o_sts.out_free  = !r_out_vld || !i_out_stall;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ sv/gss_ctrl.sv @@
// ----------------------------------------------------------------------------
// gss_ctrl
// Sequencer: clearing sweep, update passes, centre injection and reads.
// ----------------------------------------------------------------------------
module gss_ctrl #(
    parameter int CELLS         = 128,
    parameter int INJECT_RADIUS = 8,
    localparam int AW  = $clog2(CELLS),
    localparam int CW  = $clog2(CELLS + 1),
    localparam int IWW = $clog2(INJECT_RADIUS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  gss_pkg::t_in   i_in_data,
    input  gss_pkg::t_sts  i_sts,
    output gss_pkg::t_cmd  o_cmd,
    output logic [CW-1:0]  o_cnt,
    output logic [IWW-1:0] o_inj_w
);

    localparam int KW  = $clog2(2 * INJECT_RADIUS + 1);
    localparam int CSW = AW + KW + 2;
    localparam int MID = CELLS / 2;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_PASS, S_DRAIN, S_INJ, S_IDRAIN, S_RD, S_FIN
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic [KW-1:0] r_k;
    logic          r_bank, r_pass2, r_inj, r_read;

    logic                  w_acc;
    logic signed [CSW-1:0] w_cell;
    logic                  w_cell_ok;
    logic [KW-1:0]         w_d;

    always_comb begin
        w_acc     = (r_state == S_IDLE) && i_in_valid;
        w_cell    = $signed(CSW'(MID - INJECT_RADIUS)) + $signed(CSW'(r_k));
        w_cell_ok = (w_cell >= 0) && (w_cell < $signed(CSW'(CELLS)));
        w_d       = (r_k >= KW'(INJECT_RADIUS)) ? r_k - KW'(INJECT_RADIUS)
                                                : KW'(INJECT_RADIUS) - r_k;
        o_inj_w   = IWW'(KW'(INJECT_RADIUS) - w_d);
        o_cnt     = (r_state == S_INJ) ? w_cell[CW-1:0] : r_cnt;
        o_in_stall = (r_state != S_IDLE);

        o_cmd            = '0;
        o_cmd.bank       = r_bank;
        o_cmd.load       = w_acc;
        o_cmd.clr_wr     = (r_state == S_CLR);
        o_cmd.pass_ev    = (r_state == S_PASS);
        o_cmd.pass_rd    = (r_state == S_PASS) && (r_cnt < CW'(CELLS));
        o_cmd.pass_first = (r_state == S_PASS) && (r_cnt == '0);
        o_cmd.pass_last  = (r_state == S_PASS) && (r_cnt == CW'(CELLS));
        o_cmd.inj_rd     = (r_state == S_INJ) && w_cell_ok;
        o_cmd.cell_rd    = (r_state == S_RD);
        o_cmd.out_step   = (r_state == S_FIN) && i_sts.out_free && !r_read;
        o_cmd.out_read   = (r_state == S_FIN) && i_sts.out_free && r_read;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_k     <= '0;
            r_bank  <= 1'b0;
            r_pass2 <= 1'b0;
            r_inj   <= 1'b0;
            r_read  <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    r_k   <= '0;
                    if (w_acc) begin
                        r_read  <= (i_in_data.op == gss_pkg::OP_READ);
                        r_pass2 <= i_in_data.iterations[1];
                        r_inj   <= i_in_data.impact_level > gss_pkg::IMPACT_THRESHOLD;
                        r_state <= (i_in_data.op == gss_pkg::OP_READ) ? S_RD : S_PASS;
                    end
                end
                S_PASS: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(CELLS)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_cnt <= '0;
                    if (!i_sts.pipe_busy) begin
                        r_bank <= ~r_bank;
                        if (r_pass2) begin
                            r_pass2 <= 1'b0;
                            r_state <= S_PASS;
                        end else if (r_inj) begin
                            r_state <= S_INJ;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_INJ: begin
                    r_k <= r_k + KW'(1);
                    if (r_k == KW'(2 * INJECT_RADIUS)) begin
                        r_state <= S_IDRAIN;
                    end
                end
                S_IDRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_RD: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sv/gss_chk.sv @@
// ----------------------------------------------------------------------------
// gss_chk
// Port-level checks for the Gray-Scott strip step block.
// ----------------------------------------------------------------------------
module gss_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input gss_pkg::t_in                  i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input gss_pkg::t_out                 o_out_data,
    input logic                          i_cfg_we,
    input logic [gss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [15:0]                   i_cfg_wdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_stall)
        else $error("input taken during the clearing sweep");

    a_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.step_done |->
            o_out_data.cell_u == 16'd0 && o_out_data.cell_v == 16'd0)
        else $error("step beat carries cell data");

    a_conc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.cell_u <= gss_pkg::ONE_Q15
            && o_out_data.cell_v <= gss_pkg::ONE_Q15)
        else $error("concentration above one");

endmodule

bind gray_scott_strip_step gss_chk u_gss_chk (.*);
